/* design/spn_byte_decryptor_core_assert.svh */
// ----------------------------------------------------------------------------
// spn_byte_decryptor_core_assert.svh
// Assertion macros used by the byte decryptor core.
// ----------------------------------------------------------------------------
`ifndef SPN_BYTE_DECRYPTOR_CORE_ASSERT_SVH
`define SPN_BYTE_DECRYPTOR_CORE_ASSERT_SVH

// Implication checked on the same edge, clocked on clk, off during reset
`define SPN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spn: same-cycle check failed");

// Implication checked in the cycle after the antecedent, clocked on clk, off during reset
`define SPN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spn: next-cycle check failed");

`endif

/* design/spn_pkg.sv */
// ----------------------------------------------------------------------------
// spn_pkg
// Types, constants and round functions of the SPN byte decryptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spn_pkg;

  localparam int BYTE_W = 8;
  localparam int NIB_W  = 4;
  localparam int KEY_W  = 32;
  localparam int SBOX_W = 64;
  localparam int PERM_W = 32;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 5;

  localparam logic [KEY_W-1:0]  KEY_RESET  = 32'h0000_0000;
  localparam logic [SBOX_W-1:0] SBOX_RESET = 64'hFEDC_BA98_7654_3210;
  localparam logic [PERM_W-1:0] PERM_RESET = 32'h8765_4321;

  // Register indexes (paddr[4:3]); 8-byte register stride
  typedef enum logic [1:0] {
    REG_KEY  = 2'd0,
    REG_SBOX = 2'd1,
    REG_PERM = 2'd2
  } reg_idx_t;

  // Configuration bundle from the register file to the datapath
  typedef struct packed {
    logic [KEY_W-1:0]  key_word;
    logic [SBOX_W-1:0] sbox_inverse;
    logic [PERM_W-1:0] perm_inverse;
  } cfg_t;

  // Inverse bit permutation: result bit 7-i comes from input bit 8-P[i];
  // an entry outside 1..8 yields a zero bit.
  function automatic logic [BYTE_W-1:0] perm_byte(input logic [BYTE_W-1:0] v,
                                                  input logic [PERM_W-1:0] perm);
    logic [BYTE_W-1:0] r;
    logic [NIB_W-1:0]  p;
    logic [NIB_W-1:0]  idx;
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      p   = perm[NIB_W*i +: NIB_W];
      idx = 4'd8 - p;
      if (p >= 4'd1 && p <= 4'd8) begin
        r[BYTE_W-1-i] = v[idx[2:0]];
      end
    end
    return r;
  endfunction

  // One inverse S-box lookup on a nibble
  function automatic logic [NIB_W-1:0] sbox_nib(input logic [NIB_W-1:0] z,
                                                input logic [SBOX_W-1:0] sbox);
    return sbox[{z, 2'b00} +: NIB_W];
  endfunction

endpackage

/* design/spn_round.sv */
// ----------------------------------------------------------------------------
// spn_round
// One decryption round: inverse permutation, inverse S-box on both nibbles,
// round key XOR. Pure combinational.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spn_round (
  input  logic [spn_pkg::BYTE_W-1:0] din,
  input  logic [spn_pkg::BYTE_W-1:0] round_key,
  input  spn_pkg::cfg_t              cfg,
  output logic [spn_pkg::BYTE_W-1:0] dout
);

  logic [spn_pkg::BYTE_W-1:0] permuted;
  logic [spn_pkg::BYTE_W-1:0] substituted;

  // bit shuffle
  assign permuted = spn_pkg::perm_byte(din, cfg.perm_inverse);

  // nibble substitution
  assign substituted = {spn_pkg::sbox_nib(permuted[7:4], cfg.sbox_inverse),
                        spn_pkg::sbox_nib(permuted[3:0], cfg.sbox_inverse)};

  // key mix
  assign dout = substituted ^ round_key;

endmodule

/* design/spn_regs.sv */
// ----------------------------------------------------------------------------
// spn_regs
// APB register file: key, inverse S-box and inverse permutation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spn_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spn_pkg::ADDR_W-1:0] paddr,
  input  logic [spn_pkg::DATA_W-1:0] pwdata,
  output logic [spn_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output spn_pkg::cfg_t              cfg
);

  spn_pkg::cfg_t     cfg_r;
  spn_pkg::cfg_t     cfg_nxt;
  spn_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = spn_pkg::reg_idx_t'(paddr[4:3]);

  // write decode; unmapped indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        spn_pkg::REG_KEY:  cfg_nxt.key_word     = pwdata[spn_pkg::KEY_W-1:0];
        spn_pkg::REG_SBOX: cfg_nxt.sbox_inverse = pwdata;
        spn_pkg::REG_PERM: cfg_nxt.perm_inverse = pwdata[spn_pkg::PERM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_word     <= spn_pkg::KEY_RESET;
      cfg_r.sbox_inverse <= spn_pkg::SBOX_RESET;
      cfg_r.perm_inverse <= spn_pkg::PERM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      spn_pkg::REG_KEY:  prdata = {32'h0, cfg_r.key_word};
      spn_pkg::REG_SBOX: prdata = cfg_r.sbox_inverse;
      spn_pkg::REG_PERM: prdata = {32'h0, cfg_r.perm_inverse};
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* design/spn_byte_decryptor_core.sv */
// ----------------------------------------------------------------------------
// spn_byte_decryptor_core
// Three-round 8-bit SPN byte decryptor with APB configuration.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_cipher_byte and pulse start. A request is
//   taken on every edge where start is high and busy is low; busy is
//   always low, so a new byte may be issued every cycle.
//   Result channel: out_plain_byte is valid for exactly one cycle while
//   out_valid is high. The receiver cannot stall; it must take each result
//   in the cycle it appears.
//   Path: a request is captured in the input register, passes the key
//   whitening and three combinational rounds, and is strobed from the
//   result register. Throughput: one byte per cycle, as neither register
//   can stall.
//   Config: APB port, 64-bit data, registers at 0x00 (key), 0x08 (inverse
//   S-box), 0x10 (inverse permutation). Write only while idle.
//   Reset (rst_n low, synchronous): pipeline empties, key clears, S-box and
//   permutation return to the identity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spn_byte_decryptor_core_assert.svh"

module spn_byte_decryptor_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  logic [spn_pkg::BYTE_W-1:0] in_cipher_byte,
  // result channel
  output logic                       out_valid,
  output logic [spn_pkg::BYTE_W-1:0] out_plain_byte,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spn_pkg::ADDR_W-1:0] paddr,
  input  logic [spn_pkg::DATA_W-1:0] pwdata,
  output logic [spn_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  spn_pkg::cfg_t              cfg;
  logic                       in_vld_r;
  logic                       in_vld_nxt;
  logic [spn_pkg::BYTE_W-1:0] in_byte_r;
  logic                       out_valid_r;
  logic [spn_pkg::BYTE_W-1:0] out_byte_r;
  logic [spn_pkg::BYTE_W-1:0] whitened;
  logic [spn_pkg::BYTE_W-1:0] rnd2_out;
  logic [spn_pkg::BYTE_W-1:0] rnd1_out;
  logic [spn_pkg::BYTE_W-1:0] rnd0_out;
  logic                       key_wr;

  assign busy = 1'b0;

  spn_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  assign in_vld_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_nxt) begin
      in_byte_r <= in_cipher_byte;
    end
  end

  // whitening with key byte 3, then rounds with key bytes 2, 1, 0
  assign whitened = in_byte_r ^ cfg.key_word[31:24];

  spn_round u_round2 (
    .din       (whitened),
    .round_key (cfg.key_word[23:16]),
    .cfg       (cfg),
    .dout      (rnd2_out)
  );

  spn_round u_round1 (
    .din       (rnd2_out),
    .round_key (cfg.key_word[15:8]),
    .cfg       (cfg),
    .dout      (rnd1_out)
  );

  spn_round u_round0 (
    .din       (rnd1_out),
    .round_key (cfg.key_word[7:0]),
    .cfg       (cfg),
    .dout      (rnd0_out)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_byte_r <= rnd0_out;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_plain_byte = out_byte_r;

  // key register write strobe
  assign key_wr = psel && penable && pwrite && (paddr[4:3] == spn_pkg::REG_KEY);

  // checks
  `SPN_ASSERT_NEXT(a_req_loads_stage, start && !busy, in_vld_r)
  `SPN_ASSERT_NEXT(a_stage_gives_result, in_vld_r, out_valid_r)
  `SPN_ASSERT_NEXT(a_no_phantom_result, !in_vld_r, !out_valid_r)
  `SPN_ASSERT_NEXT(a_key_write_lands, key_wr, cfg.key_word == $past(pwdata[31:0]))
  `SPN_ASSERT_NOW(a_result_strobe_single, out_valid_r && !$past(in_vld_r), 1'b0)

endmodule
